### hw/rtl/ive_pkg.sv
`default_nettype none

package ive_pkg;

	// default capacity in elements
	localparam int DEPTH_DEF = 256;

	// field widths of the request and response words
	localparam int OP_W      = 4;
	localparam int IDX_W     = 9;
	localparam int DATA_W    = 32;
	localparam int ST_W      = 2;
	localparam int CNT_OUT_W = 9;

	// opcodes
	localparam logic [OP_W-1:0] OP_PUSH    = 4'd0;
	localparam logic [OP_W-1:0] OP_POP     = 4'd1;
	localparam logic [OP_W-1:0] OP_READ    = 4'd2;
	localparam logic [OP_W-1:0] OP_INSERT  = 4'd3;
	localparam logic [OP_W-1:0] OP_REMOVE  = 4'd4;
	localparam logic [OP_W-1:0] OP_UPDATE  = 4'd5;
	localparam logic [OP_W-1:0] OP_CLEAR   = 4'd6;
	localparam logic [OP_W-1:0] OP_REVERSE = 4'd7;
	localparam logic [OP_W-1:0] OP_SUM     = 4'd8;
	localparam logic [OP_W-1:0] OP_SCALE   = 4'd9;
	localparam logic [OP_W-1:0] OP_MAX     = 4'd10;
	localparam logic [OP_W-1:0] OP_MIN     = 4'd11;

	// response status codes
	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
	localparam logic [ST_W-1:0] ST_EMPTY = 2'd3;

	// store write data select
	localparam logic [1:0] WS_VAL  = 2'd0;
	localparam logic [1:0] WS_RD   = 2'd1;
	localparam logic [1:0] WS_PROD = 2'd2;
	localparam logic [1:0] WS_TMP  = 2'd3;

	// result accumulator operations
	localparam logic [2:0] ACC_HOLD = 3'd0;
	localparam logic [2:0] ACC_ZERO = 3'd1;
	localparam logic [2:0] ACC_ONES = 3'd2;
	localparam logic [2:0] ACC_LOAD = 3'd3;
	localparam logic [2:0] ACC_ADD  = 3'd4;
	localparam logic [2:0] ACC_MAX  = 3'd5;
	localparam logic [2:0] ACC_MIN  = 3'd6;

	// element count updates
	localparam logic [1:0] CNT_HOLD = 2'd0;
	localparam logic [1:0] CNT_INC  = 2'd1;
	localparam logic [1:0] CNT_DEC  = 2'd2;
	localparam logic [1:0] CNT_CLR  = 2'd3;

	typedef struct packed {
		logic [OP_W-1:0]          opcode;
		logic [IDX_W-1:0]         index;
		logic signed [DATA_W-1:0] value;
	} req_word_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] data;
		logic [ST_W-1:0]          status;
		logic [CNT_OUT_W-1:0]     count;
	} rsp_word_t;

	// per-cycle command from controller to datapath
	typedef struct packed {
		logic            rd_en;
		logic            wr_en;
		logic [1:0]      wr_sel;
		logic [2:0]      acc_op;
		logic            tmp_ld;
		logic [1:0]      cnt_op;
		logic            out_ld;
		logic [ST_W-1:0] status;
	} ive_cmd_t;

endpackage

`default_nettype wire

### hw/rtl/ive_ctrl.sv
`default_nettype none

module ive_ctrl import ive_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF,
	localparam int AW = $clog2(DEPTH),
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [OP_W-1:0]  opcode,
	input  wire logic [IDX_W-1:0] index,
	input  wire logic [CW-1:0]    count,
	input  wire logic             out_free,
	output logic                  busy,
	output ive_cmd_t              cmd,
	output logic [AW-1:0]         rd_addr,
	output logic [AW-1:0]         wr_addr
);

	localparam int XW = (CW > IDX_W) ? CW : IDX_W;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_DEC  = 4'd1;
	localparam logic [3:0] S_RUN  = 4'd2;
	localparam logic [3:0] S_WRV  = 4'd3;
	localparam logic [3:0] S_REV0 = 4'd4;
	localparam logic [3:0] S_REV1 = 4'd5;
	localparam logic [3:0] S_REV2 = 4'd6;
	localparam logic [3:0] S_REV3 = 4'd7;
	localparam logic [3:0] S_FIN  = 4'd8;

	logic [3:0]       state_q;
	logic [OP_W-1:0]  op_q;
	logic [IDX_W-1:0] idx_q;
	logic [ST_W-1:0]  st_q;
	logic [1:0]       cnt_op_q;
	logic [CW-1:0]    ptr_q;
	logic [CW-1:0]    left_q;
	logic             down_q;
	logic             v_s1;
	logic [AW-1:0]    a_s1;
	logic             v_s2;
	logic [AW-1:0]    a_s2;
	logic [AW-1:0]    lo_q;
	logic [AW-1:0]    hi_q;

	logic [XW-1:0] n_x;
	logic [XW-1:0] idx_x;
	logic [CW-1:0] idx_c;
	logic          full;
	logic          empty;
	logic          idx_lt_n;
	logic          idx_gt_n;
	logic          run_done;
	logic [AW:0]   rev_gap;

	// request index and count compared at a common width
	assign n_x      = XW'(count);
	assign idx_x    = XW'(idx_q);
	assign idx_c    = CW'(idx_x);
	assign full     = n_x >= XW'(DEPTH);
	assign empty    = count == '0;
	assign idx_lt_n = idx_x < n_x;
	assign idx_gt_n = idx_x > n_x;
	assign run_done = (left_q == '0) && !v_s1 && !v_s2;
	assign rev_gap  = {1'b0, hi_q} - {1'b0, lo_q};
	assign busy     = state_q != S_IDLE;

	// command decode per state
	always_comb begin
		cmd        = '0;
		cmd.status = st_q;
		rd_addr    = ptr_q[AW-1:0];
		wr_addr    = AW'(count);
		unique case (state_q)
			S_DEC: begin
				cmd.acc_op = ACC_ZERO;
				unique case (op_q)
					OP_PUSH: begin
						if (!full) begin
							cmd.wr_en  = 1'b1;
							cmd.wr_sel = WS_VAL;
							wr_addr    = AW'(count);
						end
					end
					OP_UPDATE: begin
						if (idx_lt_n) begin
							cmd.wr_en  = 1'b1;
							cmd.wr_sel = WS_VAL;
							wr_addr    = AW'(idx_x);
						end
					end
					OP_MAX, OP_MIN: begin
						if (empty) begin
							cmd.acc_op = ACC_ONES;
						end
					end
					default: begin
					end
				endcase
			end
			S_RUN: begin
				cmd.rd_en = left_q != '0;
				rd_addr   = ptr_q[AW-1:0];
				if (v_s1) begin
					unique case (op_q)
						OP_READ: cmd.acc_op = ACC_LOAD;
						OP_SUM:  cmd.acc_op = ACC_ADD;
						OP_MAX:  cmd.acc_op = (a_s1 == '0) ? ACC_LOAD : ACC_MAX;
						OP_MIN:  cmd.acc_op = (a_s1 == '0) ? ACC_LOAD : ACC_MIN;
						OP_INSERT: begin
							cmd.wr_en  = 1'b1;
							cmd.wr_sel = WS_RD;
							wr_addr    = a_s1 + AW'(1);
						end
						OP_REMOVE: begin
							cmd.wr_en  = 1'b1;
							cmd.wr_sel = WS_RD;
							wr_addr    = a_s1 - AW'(1);
						end
						default: begin
						end
					endcase
				end
				if (v_s2 && op_q == OP_SCALE) begin
					cmd.wr_en  = 1'b1;
					cmd.wr_sel = WS_PROD;
					wr_addr    = a_s2;
				end
			end
			S_WRV: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = WS_VAL;
				wr_addr    = AW'(idx_x);
			end
			S_REV0: begin
				cmd.rd_en = 1'b1;
				rd_addr   = lo_q;
			end
			S_REV1: begin
				cmd.rd_en  = 1'b1;
				rd_addr    = hi_q;
				cmd.tmp_ld = 1'b1;
			end
			S_REV2: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = WS_RD;
				wr_addr    = lo_q;
			end
			S_REV3: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = WS_TMP;
				wr_addr    = hi_q;
			end
			S_FIN: begin
				if (out_free) begin
					cmd.out_ld = 1'b1;
					cmd.cnt_op = cnt_op_q;
				end
			end
			default: begin
			end
		endcase
	end

	// sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			op_q     <= '0;
			idx_q    <= '0;
			st_q     <= ST_OK;
			cnt_op_q <= CNT_HOLD;
			ptr_q    <= '0;
			left_q   <= '0;
			down_q   <= 1'b0;
			v_s1     <= 1'b0;
			a_s1     <= '0;
			v_s2     <= 1'b0;
			a_s2     <= '0;
			lo_q     <= '0;
			hi_q     <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q    <= opcode;
						idx_q   <= index;
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					st_q     <= ST_OK;
					cnt_op_q <= CNT_HOLD;
					ptr_q    <= '0;
					left_q   <= count;
					down_q   <= 1'b0;
					state_q  <= S_FIN;
					unique case (op_q)
						OP_PUSH: begin
							if (full) st_q <= ST_FULL;
							else cnt_op_q <= CNT_INC;
						end
						OP_POP: begin
							if (empty) st_q <= ST_EMPTY;
							else cnt_op_q <= CNT_DEC;
						end
						OP_READ: begin
							if (idx_lt_n) begin
								ptr_q   <= idx_c;
								left_q  <= CW'(1);
								state_q <= S_RUN;
							end else begin
								st_q <= ST_RANGE;
							end
						end
						OP_INSERT: begin
							if (idx_gt_n) begin
								st_q <= ST_RANGE;
							end else if (full) begin
								st_q <= ST_FULL;
							end else begin
								ptr_q    <= count - CW'(1);
								left_q   <= count - idx_c;
								down_q   <= 1'b1;
								cnt_op_q <= CNT_INC;
								state_q  <= S_RUN;
							end
						end
						OP_REMOVE: begin
							if (!idx_lt_n) begin
								st_q <= ST_RANGE;
							end else begin
								ptr_q    <= idx_c + CW'(1);
								left_q   <= count - idx_c - CW'(1);
								cnt_op_q <= CNT_DEC;
								state_q  <= S_RUN;
							end
						end
						OP_UPDATE: begin
							if (!idx_lt_n) st_q <= ST_RANGE;
						end
						OP_CLEAR: begin
							cnt_op_q <= CNT_CLR;
						end
						OP_REVERSE: begin
							if (count > CW'(1)) begin
								lo_q    <= '0;
								hi_q    <= AW'(count - CW'(1));
								state_q <= S_REV0;
							end
						end
						OP_SUM, OP_SCALE: begin
							state_q <= S_RUN;
						end
						OP_MAX, OP_MIN: begin
							if (empty) st_q <= ST_EMPTY;
							else state_q <= S_RUN;
						end
						default: begin
						end
					endcase
				end
				S_RUN: begin
					// one read per cycle, read data is registered and returns in the next cycle
					if (left_q != '0) begin
						ptr_q  <= down_q ? ptr_q - CW'(1) : ptr_q + CW'(1);
						left_q <= left_q - CW'(1);
					end
					v_s1 <= left_q != '0;
					a_s1 <= ptr_q[AW-1:0];
					v_s2 <= v_s1;
					a_s2 <= a_s1;
					if (run_done) begin
						state_q <= (op_q == OP_INSERT) ? S_WRV : S_FIN;
					end
				end
				S_WRV:  state_q <= S_FIN;
				S_REV0: state_q <= S_REV1;
				S_REV1: state_q <= S_REV2;
				S_REV2: state_q <= S_REV3;
				S_REV3: begin
					lo_q    <= lo_q + AW'(1);
					hi_q    <= hi_q - AW'(1);
					state_q <= (rev_gap > (AW+1)'(2)) ? S_REV0 : S_FIN;
				end
				S_FIN: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

### hw/rtl/ive_dp.sv
`default_nettype none

module ive_dp import ive_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF,
	localparam int AW = $clog2(DEPTH),
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              take,
	input  wire logic [DATA_W-1:0] value,
	input  wire ive_cmd_t          cmd,
	input  wire logic [AW-1:0]     rd_addr,
	input  wire logic [AW-1:0]     wr_addr,
	input  wire logic              rsp_stall,
	output logic [CW-1:0]          count,
	output logic                   out_free,
	output logic                   rsp_valid,
	output rsp_word_t              rsp
);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] val_q;
	logic [DATA_W-1:0] rdata_q;
	logic [DATA_W-1:0] prod_s2;
	logic [DATA_W-1:0] tmp_q;
	logic [DATA_W-1:0] acc_q;
	logic [DATA_W-1:0] wdata;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     count_d;
	logic              rsp_valid_q;
	rsp_word_t         rsp_q;

	// element store, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (cmd.wr_en) mem_q[wr_addr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) rdata_q <= mem_q[rd_addr];
	end

	// write data select
	always_comb begin
		unique case (cmd.wr_sel)
			WS_VAL:  wdata = val_q;
			WS_RD:   wdata = rdata_q;
			WS_PROD: wdata = prod_s2;
			WS_TMP:  wdata = tmp_q;
			default: wdata = val_q;
		endcase
	end

	// request value, swap holding word and wrapped product
	always_ff @(posedge clk) begin
		if (take) val_q <= value;
		if (cmd.tmp_ld) tmp_q <= rdata_q;
		prod_s2 <= DATA_W'(rdata_q * val_q);
	end

	// result accumulator: sum, max, min or read word, cleared to zero or set to all ones
	always_ff @(posedge clk) begin
		unique case (cmd.acc_op)
			ACC_ZERO: acc_q <= '0;
			ACC_ONES: acc_q <= '1;
			ACC_LOAD: acc_q <= rdata_q;
			ACC_ADD:  acc_q <= acc_q + rdata_q;
			ACC_MAX:  if ($signed(rdata_q) > $signed(acc_q)) acc_q <= rdata_q;
			ACC_MIN:  if ($signed(rdata_q) < $signed(acc_q)) acc_q <= rdata_q;
			default: begin
			end
		endcase
	end

	// element count update
	always_comb begin
		unique case (cmd.cnt_op)
			CNT_INC:  count_d = count_q + CW'(1);
			CNT_DEC:  count_d = count_q - CW'(1);
			CNT_CLR:  count_d = '0;
			default:  count_d = count_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) count_q <= '0;
		else count_q <= count_d;
	end

	// response word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.out_ld) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			rsp_q.data   <= acc_q;
			rsp_q.status <= cmd.status;
			rsp_q.count  <= CNT_OUT_W'(count_d);
		end
	end

	assign count     = count_q;
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

### hw/rtl/indexed_vector_engine_top.sv
// push, pop, update, clear, a bad index, max/min on empty, reverse of at most one element and
// unused opcodes go straight from decode to the response register; read, sum, max, min, scale
// and remove walk the store; insert walks, then writes the new value; reverse reads both ends
// of each pair and writes them back swapped; walks move one element per cycle
// one request in flight; next is taken the cycle after the response registers; stalls delay it
// reset (arst_n low) clears the element count and the response valid; store contents are kept
`default_nettype none

module indexed_vector_engine_top import ive_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      req_valid,
	output logic           req_stall,
	input  wire req_word_t req,
	output logic           rsp_valid,
	input  wire logic      rsp_stall,
	output rsp_word_t      rsp
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	ive_cmd_t      cmd;
	logic          busy;
	logic          take;
	logic          out_free;
	logic [CW-1:0] count;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;

	// request word taken only when the sequencer is idle
	assign req_stall = busy;
	assign take      = req_valid && !busy;

	ive_ctrl #(.DEPTH(DEPTH)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (take),
		.opcode   (req.opcode),
		.index    (req.index),
		.count    (count),
		.out_free (out_free),
		.busy     (busy),
		.cmd      (cmd),
		.rd_addr  (rd_addr),
		.wr_addr  (wr_addr)
	);

	ive_dp #(.DEPTH(DEPTH)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.value     (req.value),
		.cmd       (cmd),
		.rd_addr   (rd_addr),
		.wr_addr   (wr_addr),
		.rsp_stall (rsp_stall),
		.count     (count),
		.out_free  (out_free),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire

### hw/rtl/ive_chk.sv
`default_nettype none

module ive_chk import ive_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      req_valid,
	input wire logic      req_stall,
	input wire req_word_t req,
	input wire logic      rsp_valid,
	input wire logic      rsp_stall,
	input wire rsp_word_t rsp
);

	// stalled response word holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response word changed while stalled");

	// one request at a time: stall follows every accepted word
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request accepted while previous one in flight");

	// empty status only with no elements left
	a_empty_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_EMPTY |-> rsp.count == '0)
		else $error("empty status with nonzero count");

	// full status only at capacity
	a_full_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_FULL |-> rsp.count == CNT_OUT_W'(DEPTH))
		else $error("full status below capacity");

	// count never passes capacity
	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> 32'(rsp.count) <= 32'(DEPTH))
		else $error("count above capacity");

endmodule

bind indexed_vector_engine_top ive_chk #(.DEPTH(DEPTH)) u_ive_chk (.*);

`default_nettype wire

### sim/tb_indexed_vector_engine_top.sv
module tb_indexed_vector_engine_top;
	import ive_pkg::*;

	// opcodes with no operation behind them
	localparam logic [OP_W-1:0] OP_UNUSED_FIRST = 4'd12;
	localparam logic [OP_W-1:0] OP_UNUSED_LAST  = 4'd15;

	// longest walk is a reverse of a full vector
	localparam int SETTLE_CYCLES = 600;
	localparam int STALL_LIMIT   = 5000;

	logic      clk;
	logic      arst_n;
	logic      req_valid;
	logic      req_stall;
	req_word_t req;
	logic      rsp_valid;
	logic      rsp_stall;
	rsp_word_t rsp;

	// shadow copy of the vector
	logic signed [DATA_W-1:0] vec_mem [0:DEPTH_DEF-1];
	int unsigned              vec_len;

	// responses still owed by the block, oldest first
	rsp_word_t awaited_rsp [$];

	int unsigned send_idle_pct;
	int unsigned rsp_stall_pct;
	int unsigned mismatches;

	indexed_vector_engine_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// apply one request to the shadow vector and return the response it owes
	function automatic rsp_word_t apply_vector_op(req_word_t w);
		rsp_word_t                r;
		int unsigned              n;
		int unsigned              idx;
		int unsigned              i;
		int unsigned              lo;
		int unsigned              hi;
		logic signed [DATA_W-1:0] t;
		r        = '0;
		r.status = ST_OK;
		n        = vec_len;
		idx      = w.index;
		case (w.opcode)
			OP_PUSH: begin
				if (n >= DEPTH_DEF) begin
					r.status = ST_FULL;
				end else begin
					vec_mem[n] = w.value;
					n++;
				end
			end
			OP_POP: begin
				if (n == 0) r.status = ST_EMPTY;
				else n--;
			end
			OP_READ: begin
				if (idx < n) r.data = vec_mem[idx];
				else r.status = ST_RANGE;
			end
			OP_INSERT: begin
				if (idx > n) begin
					r.status = ST_RANGE;
				end else if (n >= DEPTH_DEF) begin
					r.status = ST_FULL;
				end else begin
					for (i = n; i > idx; i--) vec_mem[i] = vec_mem[i-1];
					vec_mem[idx] = w.value;
					n++;
				end
			end
			OP_REMOVE: begin
				if (idx >= n) begin
					r.status = ST_RANGE;
				end else begin
					for (i = idx; i + 1 < n; i++) vec_mem[i] = vec_mem[i+1];
					n--;
				end
			end
			OP_UPDATE: begin
				if (idx >= n) r.status = ST_RANGE;
				else vec_mem[idx] = w.value;
			end
			OP_CLEAR: begin
				n = 0;
			end
			OP_REVERSE: begin
				if (n > 1) begin
					lo = 0;
					hi = n - 1;
					while (lo < hi) begin
						t           = vec_mem[lo];
						vec_mem[lo] = vec_mem[hi];
						vec_mem[hi] = t;
						lo++;
						hi--;
					end
				end
			end
			OP_SUM: begin
				for (i = 0; i < n; i++) r.data = r.data + vec_mem[i];
			end
			OP_SCALE: begin
				for (i = 0; i < n; i++) vec_mem[i] = vec_mem[i] * w.value;
			end
			OP_MAX, OP_MIN: begin
				if (n == 0) begin
					r.data   = -1;
					r.status = ST_EMPTY;
				end else begin
					r.data = vec_mem[0];
					for (i = 1; i < n; i++) begin
						if (w.opcode == OP_MAX ? vec_mem[i] > r.data : vec_mem[i] < r.data)
							r.data = vec_mem[i];
					end
				end
			end
			default: begin
			end
		endcase
		vec_len = n;
		r.count = n[CNT_OUT_W-1:0];
		return r;
	endfunction

	// extremes, small values and plain random words
	function automatic logic signed [DATA_W-1:0] random_value();
		case ($urandom_range(0, 7))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return $signed($urandom_range(0, 8)) - 4;
			default: return $urandom();
		endcase
	endfunction

	// mostly in-range edits with random content, some bad indexes and unused opcodes
	function automatic req_word_t random_request();
		req_word_t   w;
		int unsigned n;
		int unsigned pick;
		n       = vec_len;
		pick    = $urandom_range(0, 99);
		w.value = random_value();
		if ($urandom_range(0, 99) < 85) w.index = IDX_W'($urandom_range(0, n));
		else w.index = IDX_W'($urandom_range(0, DEPTH_DEF));
		if (pick < 3) w.opcode = OP_W'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
		else if (pick < 25) w.opcode = OP_PUSH;
		else if (pick < 33) w.opcode = OP_POP;
		else if (pick < 46) w.opcode = OP_READ;
		else if (pick < 60) w.opcode = OP_INSERT;
		else if (pick < 71) w.opcode = OP_REMOVE;
		else if (pick < 79) w.opcode = OP_UPDATE;
		else if (pick < 81) w.opcode = OP_CLEAR;
		else if (pick < 86) w.opcode = OP_REVERSE;
		else if (pick < 90) w.opcode = OP_SUM;
		else if (pick < 93) w.opcode = OP_SCALE;
		else if (pick < 97) w.opcode = OP_MAX;
		else w.opcode = OP_MIN;
		// keep the vector short so walks stay cheap
		if (n > 48 && (w.opcode == OP_PUSH || w.opcode == OP_INSERT)) w.opcode = OP_REMOVE;
		// small factors keep scaled words readable
		if (w.opcode == OP_SCALE && $urandom_range(0, 3) != 0)
			w.value = $signed($urandom_range(0, 6)) - 3;
		return w;
	endfunction

	// present one request word and hold it until taken; valid stays high afterwards
	task automatic send_word(input req_word_t w);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= w;
		do @(posedge clk); while (req_stall);
		awaited_rsp.push_back(apply_vector_op(w));
	endtask

	task automatic send_op(input logic [OP_W-1:0] op, input int unsigned idx,
			input logic signed [DATA_W-1:0] val);
		req_word_t w;
		w.opcode = op;
		w.index  = idx[IDX_W-1:0];
		w.value  = val;
		send_word(w);
	endtask

	// drop valid and let every owed response come back
	task automatic wait_for_idle();
		req_valid <= 1'b0;
		while (awaited_rsp.size() != 0) @(posedge clk);
	endtask

	// every operation but push on an empty vector, plus the unused opcodes
	task automatic test_empty_vector();
		int unsigned k;
		send_op(OP_POP, 0, 0);
		send_op(OP_READ, 0, 0);
		send_op(OP_REMOVE, 0, 0);
		send_op(OP_UPDATE, 0, 5);
		send_op(OP_MAX, 0, 0);
		send_op(OP_MIN, 0, 0);
		send_op(OP_SUM, 0, 0);
		send_op(OP_REVERSE, 0, 0);
		send_op(OP_SCALE, 0, 3);
		send_op(OP_INSERT, 1, 9);
		send_op(OP_CLEAR, 0, 0);
		for (k = OP_UNUSED_FIRST; k <= OP_UNUSED_LAST; k++) send_op(OP_W'(k), k, -1);
		wait_for_idle();
	endtask

	// edits at both ends and in the middle, wrapping sum and scale, odd and even reverse
	task automatic test_edit_ops();
		send_op(OP_PUSH, 0, 32'sh7fffffff);
		send_op(OP_PUSH, 0, 32'sh80000000);
		send_op(OP_INSERT, 0, -1);
		send_op(OP_INSERT, 3, 0);
		send_op(OP_INSERT, 1, 1);
		send_op(OP_READ, 0, 0);
		send_op(OP_READ, 4, 0);
		send_op(OP_READ, 5, 0);
		send_op(OP_READ, DEPTH_DEF, 0);
		send_op(OP_SUM, 0, 0);
		send_op(OP_MAX, 0, 0);
		send_op(OP_MIN, 0, 0);
		send_op(OP_REVERSE, 0, 0);
		send_op(OP_READ, 0, 0);
		send_op(OP_UPDATE, 2, 32'sh55555555);
		send_op(OP_UPDATE, DEPTH_DEF, 7);
		send_op(OP_REMOVE, 0, 0);
		send_op(OP_REMOVE, 3, 0);
		send_op(OP_REMOVE, DEPTH_DEF, 0);
		send_op(OP_PUSH, 0, 32'sh7fffffff);
		send_op(OP_REVERSE, 0, 0);
		send_op(OP_SCALE, 0, -1);
		send_op(OP_SCALE, 0, 32'sh80000000);
		send_op(OP_SUM, 0, 0);
		send_op(OP_POP, 0, 0);
		send_op(OP_CLEAR, 0, 0);
		wait_for_idle();
	endtask

	// fill to capacity, hit the full cases, walk the whole vector
	task automatic test_full_capacity();
		int unsigned k;
		for (k = 0; k < DEPTH_DEF; k++) send_op(OP_PUSH, k, random_value());
		send_op(OP_PUSH, 0, 11);
		send_op(OP_INSERT, 0, 12);
		send_op(OP_INSERT, DEPTH_DEF, 13);
		send_op(OP_READ, DEPTH_DEF - 1, 0);
		send_op(OP_READ, DEPTH_DEF, 0);
		send_op(OP_UPDATE, DEPTH_DEF - 1, 32'sh80000000);
		send_op(OP_MAX, 0, 0);
		send_op(OP_MIN, 0, 0);
		send_op(OP_SUM, 0, 0);
		send_op(OP_REVERSE, 0, 0);
		send_op(OP_SCALE, 0, 3);
		send_op(OP_REMOVE, 0, 0);
		send_op(OP_INSERT, DEPTH_DEF - 1, 32'sh7fffffff);
		send_op(OP_INSERT, 100, 14);
		send_op(OP_READ, 0, 0);
		send_op(OP_POP, 0, 0);
		send_op(OP_CLEAR, 0, 0);
		wait_for_idle();
	endtask

	// random words under one idling pattern
	task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_pct,
			input int unsigned words);
		int unsigned k;
		send_idle_pct = idle_pct;
		rsp_stall_pct = stall_pct;
		for (k = 0; k < words; k++) send_word(random_request());
		wait_for_idle();
	endtask

	// response side stalls at random
	always @(posedge clk) begin
		rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
	end

	// compare each taken response with the oldest owed one
	always @(posedge clk) begin
		rsp_word_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (awaited_rsp.size() == 0) begin
				$display("%0t: unexpected response, expected none actual data %0d status %0d count %0d",
					$time, rsp.data, rsp.status, rsp.count);
				mismatches++;
			end else begin
				want = awaited_rsp.pop_front();
				if (rsp.data !== want.data) begin
					$display("%0t: data mismatch, expected %0d actual %0d",
						$time, want.data, rsp.data);
					mismatches++;
				end
				if (rsp.status !== want.status) begin
					$display("%0t: status mismatch, expected %0d actual %0d",
						$time, want.status, rsp.status);
					mismatches++;
				end
				if (rsp.count !== want.count) begin
					$display("%0t: count mismatch, expected %0d actual %0d",
						$time, want.count, rsp.count);
					mismatches++;
				end
			end
		end
	end

	// give up when neither channel moves for too long
	initial begin
		int unsigned quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
			else quiet++;
		end
		$display("%0t: no word moved for %0d cycles, %0d responses owed",
			$time, STALL_LIMIT, awaited_rsp.size());
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		arst_n        = 1'b0;
		req_valid     = 1'b0;
		req           = '0;
		rsp_stall     = 1'b0;
		send_idle_pct = 0;
		rsp_stall_pct = 0;
		mismatches    = 0;
		vec_len       = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		test_empty_vector();
		test_edit_ops();
		test_full_capacity();
		test_random_traffic(0, 0, 215);
		test_random_traffic(67, 0, 215);
		test_random_traffic(0, 67, 215);
		test_random_traffic(35, 35, 215);

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
